[hdl/whp_pkg.sv]
// Shared types and constants for the wave header probe.
`timescale 1ns / 1ps
package whp_pkg;

  localparam int unsigned MaxBufferBytes = 65536;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;
  localparam logic [31:0] FMT_BODY_MIN = 32'd16;
  localparam logic [31:0] RATE_RESET = 32'd16000;

  // Parse phases
  localparam logic [2:0] PH_RIFF  = 3'd0;
  localparam logic [2:0] PH_CHUNK = 3'd1;
  localparam logic [2:0] PH_FMT   = 3'd2;
  localparam logic [2:0] PH_SKIP  = 3'd3;
  localparam logic [2:0] PH_STOP  = 3'd4;

  // Verdict codes
  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_NOT_RIFF = 4'd1;
  localparam logic [3:0] ST_FMT_TRUNC = 4'd2;
  localparam logic [3:0] ST_NO_FMT   = 4'd3;
  localparam logic [3:0] ST_NOT_PCM  = 4'd4;
  localparam logic [3:0] ST_NOT_16   = 4'd5;
  localparam logic [3:0] ST_NOT_MONO = 4'd6;
  localparam logic [3:0] ST_BAD_RATE = 4'd7;
  localparam logic [3:0] ST_NO_DATA  = 4'd8;

  // Commands from controller to datapath
  typedef struct packed {
    logic take;      // parse the input item
    logic finish;    // latch verdict, start division
    logic div_step;  // high in the divide state; not used by the datapath
    logic clear;     // clear parse state
  } whp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic div_done;
  } whp_sts_t;

endpackage

[hdl/whp_ctrl.sv]
// Controller: sequences byte intake, verdict division and result hand-off.
`timescale 1ns / 1ps
module whp_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_last,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  output whp_pkg::whp_cmd_t cmd,
  input  whp_pkg::whp_sts_t sts
);

  localparam logic [1:0] S_TAKE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       acc;

  assign in_tready  = (state_r == S_TAKE);
  assign out_tvalid = (state_r == S_OUT);
  assign acc        = in_tvalid && in_tready;

  // Drive datapath commands
  always_comb begin
    cmd.take     = acc;
    cmd.finish   = acc && in_last;
    cmd.div_step = (state_r == S_DIV);
    cmd.clear    = 1'b0;
  end

  // Advance the state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_TAKE: if (acc && in_last) state_nxt = S_DIV;
      S_DIV: if (sts.div_done) state_nxt = S_OUT;
      S_OUT: if (out_tready) state_nxt = S_TAKE;
      default: state_nxt = S_TAKE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_TAKE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTH
  a_no_take_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken while result pending");
  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("result dropped");
  a_last_to_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> state_r == S_DIV) else $error("finish without divide");
`endif

endmodule

[hdl/whp_datapath.sv]
// Datapath: header parse registers, verdict logic and restoring divider.
`timescale 1ns / 1ps
module whp_datapath #(
  parameter int unsigned MAX_BUFFER_BYTES = whp_pkg::MaxBufferBytes,
  localparam int unsigned PW = $clog2(MAX_BUFFER_BYTES + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  whp_pkg::whp_cmd_t cmd,
  output whp_pkg::whp_sts_t sts,
  input  logic [7:0]        header_byte,
  input  logic              cfg_valid,
  input  logic [31:0]       cfg_data,
  output logic [3:0]        status,
  output logic [15:0]       format_tag,
  output logic [31:0]       file_rate,
  output logic [15:0]       channel_count,
  output logic [15:0]       sample_bits,
  output logic [PW-1:0]     body_start,
  output logic [31:0]       body_len,
  output logic [31:0]       play_ms,
  output logic              past_buffer,
  output logic [PW-1:0]     bytes_after_data
);

  localparam logic [PW-1:0] MAXB = PW'(MAX_BUFFER_BYTES);

  logic [31:0]   rate_r;
  logic [PW-1:0] pos_r;
  logic [2:0]    ph_r;
  logic [63:0]   sh_r;
  logic [32:0]   rem_r;
  logic [4:0]    idx_r;
  logic [15:0]   fmt_r, ch_r, bits_r;
  logic [31:0]   srate_r;
  logic          f_fmt_r, f_data_r, f_bad_r, f_badfmt_r;
  logic [PW-1:0] doff_r;
  logic [31:0]   dsize_r;
  logic          div_clear_r;

  // Parse step combinational values
  logic [63:0] sh_new;
  logic [31:0] top, tag, csize;
  logic        live;
  logic [3:0]  fi;

  assign sh_new = {header_byte, sh_r[63:8]};
  assign top    = sh_new[63:32];
  assign tag    = sh_new[31:0];
  assign csize  = sh_new[63:32];
  assign live   = pos_r < MAXB;
  assign fi     = idx_r[3:0];

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= whp_pkg::RATE_RESET;
    end else if (cfg_valid) begin
      rate_r <= cfg_data;
    end
  end

  // Parse header bytes
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear || div_clear_r) begin
      pos_r <= '0; ph_r <= whp_pkg::PH_RIFF; sh_r <= '0; rem_r <= '0; idx_r <= '0;
      fmt_r <= '0; ch_r <= '0; srate_r <= '0; bits_r <= '0;
      f_fmt_r <= 1'b0; f_data_r <= 1'b0; f_bad_r <= 1'b0; f_badfmt_r <= 1'b0;
      doff_r <= '0; dsize_r <= '0;
    end else if (cmd.take && live) begin
      pos_r <= pos_r + PW'(1);
      sh_r  <= sh_new;
      case (ph_r)
        whp_pkg::PH_RIFF: begin
          if (pos_r == PW'(3) && top != whp_pkg::TAG_RIFF) f_bad_r <= 1'b1;
          if (pos_r == PW'(11)) begin
            idx_r <= '0;
            if (f_bad_r || top != whp_pkg::TAG_WAVE) begin
              f_bad_r <= 1'b1;
              ph_r <= whp_pkg::PH_STOP;
            end else begin
              ph_r <= whp_pkg::PH_CHUNK;
            end
          end
        end
        whp_pkg::PH_CHUNK: begin
          if (idx_r >= 5'd7) begin
            rem_r <= {1'b0, csize} + {32'd0, csize[0]};
            idx_r <= '0;
            if (tag == whp_pkg::TAG_FMT) begin
              if (csize < whp_pkg::FMT_BODY_MIN) begin
                f_badfmt_r <= 1'b1;
                ph_r <= whp_pkg::PH_STOP;
              end else begin
                ph_r <= whp_pkg::PH_FMT;
              end
            end else if (tag == whp_pkg::TAG_DATA) begin
              doff_r <= pos_r + PW'(1);
              dsize_r <= csize;
              f_data_r <= 1'b1;
              ph_r <= whp_pkg::PH_STOP;
            end else begin
              ph_r <= ((({1'b0, csize} + {32'd0, csize[0]}) != 33'd0) ?
                       whp_pkg::PH_SKIP : whp_pkg::PH_CHUNK);
            end
          end else begin
            idx_r <= idx_r + 5'd1;
          end
        end
        whp_pkg::PH_FMT: begin
          case (fi)
            4'd0: fmt_r[7:0] <= header_byte;
            4'd1: fmt_r[15:8] <= header_byte;
            4'd2: ch_r[7:0] <= header_byte;
            4'd3: ch_r[15:8] <= header_byte;
            4'd4: srate_r[7:0] <= header_byte;
            4'd5: srate_r[15:8] <= header_byte;
            4'd6: srate_r[23:16] <= header_byte;
            4'd7: srate_r[31:24] <= header_byte;
            4'd14: bits_r[7:0] <= header_byte;
            4'd15: bits_r[15:8] <= header_byte;
            default: ;
          endcase
          rem_r <= rem_r - 33'd1;
          if (idx_r >= 5'd15) begin
            f_fmt_r <= 1'b1;
            idx_r <= '0;
            ph_r <= (rem_r != 33'd1) ? whp_pkg::PH_SKIP : whp_pkg::PH_CHUNK;
          end else begin
            idx_r <= idx_r + 5'd1;
          end
        end
        whp_pkg::PH_SKIP: begin
          rem_r <= rem_r - 33'd1;
          if (rem_r == 33'd1) begin
            idx_r <= '0;
            ph_r <= whp_pkg::PH_CHUNK;
          end
        end
        default: ;
      endcase
    end
  end

  // Verdict on the final byte, with the length and phase after that byte
  logic [2:0]    ph_f;
  logic          bad_f, badfmt_f, fmtok_f;
  logic [PW-1:0] len_f;
  logic [3:0]    st_c;

  // Final byte only updates flags that matter through registered state;
  // the verdict is evaluated in the cycle after the last item, from registers.
  assign ph_f = ph_r; assign bad_f = f_bad_r; assign badfmt_f = f_badfmt_r;
  assign fmtok_f = f_fmt_r; assign len_f = pos_r;

  always_comb begin
    if (ph_f == whp_pkg::PH_RIFF || bad_f) st_c = whp_pkg::ST_NOT_RIFF;
    else if (badfmt_f || ph_f == whp_pkg::PH_FMT) st_c = whp_pkg::ST_FMT_TRUNC;
    else if (!fmtok_f) st_c = whp_pkg::ST_NO_FMT;
    else if (fmt_r != 16'd1) st_c = whp_pkg::ST_NOT_PCM;
    else if (bits_r != 16'd16) st_c = whp_pkg::ST_NOT_16;
    else if (ch_r != 16'd1) st_c = whp_pkg::ST_NOT_MONO;
    else if (srate_r != rate_r) st_c = whp_pkg::ST_BAD_RATE;
    else if (!f_data_r) st_c = whp_pkg::ST_NO_DATA;
    else st_c = whp_pkg::ST_OK;
  end

  // Restoring divider: dsize*1000 / (2*rate), one quotient bit per cycle
  logic          pend_r;     // verdict to be latched next cycle
  logic          dbusy_r;
  logic [5:0]    dcnt_r;
  logic [41:0]   dnum_r;
  logic [33:0]   dden_r;
  logic [34:0]   drem_r;
  logic [41:0]   dq_r;
  logic [34:0]   dtrial;
  logic [41:0]   prod;
  logic          ok_r;

  assign prod   = 42'(dsize_r) * 42'd1000;
  assign dtrial = {drem_r[33:0], dnum_r[41]} - {1'b0, dden_r};
  assign sts.div_done = ok_r ? (!pend_r && !dbusy_r) : !pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0; dbusy_r <= 1'b0; div_clear_r <= 1'b0;
    end else begin
      pend_r <= cmd.finish;
      div_clear_r <= pend_r;
      if (pend_r) begin
        dbusy_r <= (st_c == whp_pkg::ST_OK) && (rate_r != 32'd0);
      end else if (dbusy_r && dcnt_r == 6'd41) begin
        dbusy_r <= 1'b0;
      end
    end
  end

  // Latch results and run the divider
  always_ff @(posedge clk) begin
    if (pend_r) begin
      ok_r  <= (st_c == whp_pkg::ST_OK);
      status <= st_c;
      format_tag <= (st_c == whp_pkg::ST_OK || st_c == whp_pkg::ST_NOT_PCM) ? fmt_r : '0;
      file_rate <= (st_c == whp_pkg::ST_OK || st_c == whp_pkg::ST_BAD_RATE) ? srate_r : '0;
      channel_count <= (st_c == whp_pkg::ST_OK) ? ch_r : '0;
      sample_bits <= (st_c == whp_pkg::ST_OK) ? bits_r : '0;
      body_start <= (st_c == whp_pkg::ST_OK) ? doff_r : '0;
      body_len <= (st_c == whp_pkg::ST_OK) ? dsize_r : '0;
      bytes_after_data <= (st_c == whp_pkg::ST_OK) ? (len_f - doff_r) : '0;
      past_buffer <= (st_c == whp_pkg::ST_OK) &&
                     ({1'b0, dsize_r} > 33'(len_f - doff_r));
      play_ms <= (st_c == whp_pkg::ST_OK && rate_r == 32'd0) ? 32'hFFFF_FFFF : '0;
      dnum_r <= prod;
      dden_r <= {1'b0, rate_r, 1'b0};
      drem_r <= '0;
      dq_r   <= '0;
      dcnt_r <= '0;
    end else if (dbusy_r) begin
      dcnt_r <= dcnt_r + 6'd1;
      dnum_r <= {dnum_r[40:0], 1'b0};
      if (!dtrial[34]) begin
        drem_r <= dtrial;
        dq_r <= {dq_r[40:0], 1'b1};
      end else begin
        drem_r <= {drem_r[33:0], dnum_r[41]};
        dq_r <= {dq_r[40:0], 1'b0};
      end
      if (dcnt_r == 6'd41)
        play_ms <= (!dtrial[34]) ? {dq_r[30:0], 1'b1} : {dq_r[30:0], 1'b0};
    end
  end

`ifndef SYNTH
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= MAXB) else $error("byte position past buffer limit");
  a_clear_after_pend: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |=> div_clear_r) else $error("parse state not cleared");
  a_div_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    dbusy_r && !pend_r |-> ok_r) else $error("divider ran on failure");
`endif

endmodule

[hdl/wav_header_probe.sv]
// Top level of the wave header probe.
`timescale 1ns / 1ps
// Usage:
// Feed header bytes on the in_ stream, one item per byte, with in_tlast on
// the final byte of the buffer. Bytes are taken back to back while in_tready
// is high. After the final byte the block latches the verdict, then, on a
// successful header with a nonzero required rate, runs the duration
// division as a 42-step restoring divider, one quotient bit per cycle; on
// failure or a zero required rate no division runs. While the verdict is
// pending or waiting on out_tready, in_tready stays low; it rises the cycle
// after the result item is taken. Bytes past MAX_BUFFER_BYTES are accepted
// and ignored. The cfg_ channel writes the required sample rate; write it
// only while the block is idle. Reset (rst_n low, synchronous) clears all
// parse state and sets the required rate to 16000; no result is pending
// after it.
module wav_header_probe #(
  parameter int unsigned MAX_BUFFER_BYTES = whp_pkg::MaxBufferBytes,
  localparam int unsigned PW = $clog2(MAX_BUFFER_BYTES + 1)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [7:0]     in_tdata,    // header_byte
  input  logic           in_tlast,    // last_byte
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [31:0]    cfg_data,    // required_rate
  output logic           out_tvalid,
  input  logic           out_tready,
  // status, format_tag, file rate, channel_count, sample_bits, body start,
  // body length, play time in ms, past_buffer, bytes_after_data (low bit up)
  output logic [((4+16+32+16+16+PW+32+32+1+PW)+7)/8*8-1:0] out_tdata
);

  localparam int unsigned DW = 4 + 16 + 32 + 16 + 16 + PW + 32 + 32 + 1 + PW;
  localparam int unsigned TW = (DW + 7) / 8 * 8;

  whp_pkg::whp_cmd_t cmd;
  whp_pkg::whp_sts_t sts;
  logic [3:0]    status;
  logic [15:0]   format_tag, channel_count, sample_bits;
  logic [31:0]   file_rate, body_len, play_ms;
  logic [PW-1:0] body_start, bytes_after_data;
  logic          past_buffer;

  assign cfg_ready = 1'b1;

  whp_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_last(in_tlast), .in_tready,
    .out_tvalid, .out_tready, .cmd, .sts
  );

  whp_datapath #(.MAX_BUFFER_BYTES(MAX_BUFFER_BYTES)) u_dp (
    .clk, .rst_n, .cmd, .sts, .header_byte(in_tdata),
    .cfg_valid, .cfg_data,
    .status, .format_tag, .file_rate, .channel_count, .sample_bits,
    .body_start, .body_len, .play_ms, .past_buffer, .bytes_after_data
  );

  // Pack the result item
  assign out_tdata = TW'({bytes_after_data, past_buffer, play_ms, body_len,
                          body_start, sample_bits, channel_count, file_rate,
                          format_tag, status});

endmodule
